// ===== design/odd_pkg.sv =====
// Shared types and codes for the ordered deque.
`default_nettype none
package odd_pkg;

   typedef enum logic [2:0] {
      OP_INSERT_FRONT = 3'd0,
      OP_INSERT_BACK  = 3'd1,
      OP_DELETE       = 3'd2,
      OP_DUMP_FWD     = 3'd3,
      OP_DUMP_BWD     = 3'd4
   } req_op_type;

   typedef enum logic [2:0] {
      STAT_INSERTED  = 3'd0,
      STAT_FULL      = 3'd1,
      STAT_DELETED   = 3'd2,
      STAT_NOT_FOUND = 3'd3,
      STAT_ELEMENT   = 3'd4,
      STAT_EMPTY     = 3'd5
   } rsp_status_type;

   typedef struct packed {
      req_op_type         op;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      rsp_status_type     status;
      logic signed [31:0] element;
      logic               last;
   } rsp_type;

   typedef enum logic [2:0] {
      CELL_HOLD      = 3'd0,
      CELL_SHIFT_IN  = 3'd1,
      CELL_LOAD      = 3'd2,
      CELL_DELETE    = 3'd3,
      CELL_ROT_LEFT  = 3'd4,
      CELL_ROT_RIGHT = 3'd5
   } cell_op_type;

   typedef struct packed {
      cell_op_type        op;
      logic signed [31:0] data;
   } cell_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_DELETE = 2'd1,
      ST_DUMP   = 2'd2
   } state_type;

endpackage
`default_nettype wire

// ===== design/odd_cell.sv =====
// One list slot: holds an entry and moves it to or from its neighbors.
`default_nettype none
module odd_cell
   import odd_pkg::*;
#(
   parameter int unsigned DEPTH = 16,
   parameter int unsigned INDEX = 0,
   localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
   input  wire logic                clock,
   input  wire cell_cmd_type        cmd,
   input  wire logic [CntW-1:0]     count,
   input  wire logic signed [31:0]  left_value,
   input  wire logic signed [31:0]  right_value,
   input  wire logic                found_in,
   output logic signed [31:0]       value,
   output logic                     found_out
);

   localparam logic [CntW-1:0] IdxHere = CntW'(INDEX);
   localparam logic [CntW-1:0] IdxNext = CntW'(INDEX + 1);

   logic signed [31:0] value_ff;
   logic signed [31:0] value_in;
   logic               match;

   always_comb begin
      match     = (IdxHere < count) && (value_ff == cmd.data);
      found_out = found_in | match;
      value_in  = value_ff;
      unique case (cmd.op)
         CELL_HOLD:      value_in = value_ff;
         CELL_SHIFT_IN:  value_in = left_value;
         CELL_LOAD:      value_in = (IdxHere == count) ? cmd.data : value_ff;
         // every slot at or past the first match pulls from the right
         CELL_DELETE:    value_in = found_out ? right_value : value_ff;
         CELL_ROT_LEFT: begin
            if (IdxNext == count) begin
               value_in = cmd.data;
            end else if (IdxNext < count) begin
               value_in = right_value;
            end else begin
               value_in = value_ff;
            end
         end
         // slot 0 sees the tail on its left input
         CELL_ROT_RIGHT: value_in = (IdxHere < count) ? left_value : value_ff;
         default:        value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule
`default_nettype wire

// ===== design/odd_ctrl.sv =====
// Sequencer: decodes commands, keeps the entry count, issues cell commands, forms results.
`default_nettype none
module odd_ctrl
   import odd_pkg::*;
#(
   parameter int unsigned DEPTH = 16,
   localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire req_type            req_data,
   output logic                    busy,
   output logic                    rsp_strobe,
   output rsp_type                 rsp_data,
   output logic [CntW-1:0]         count,
   output cell_cmd_type            cmd,
   input  wire logic signed [31:0] head_value,
   input  wire logic signed [31:0] tail_value,
   input  wire logic               found
);

   localparam logic [CntW-1:0] Full = CntW'(DEPTH);

   state_type          state_ff, state_in;
   logic [CntW-1:0]    count_ff, count_in;
   logic [CntW-1:0]    remain_ff, remain_in;
   logic               backward_ff, backward_in;
   logic signed [31:0] value_ff, value_in;
   logic               strobe_ff, strobe_in;
   rsp_type            rsp_ff, rsp_in;
   logic signed [31:0] dump_value;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      remain_in   = remain_ff;
      backward_in = backward_ff;
      value_in    = value_ff;
      strobe_in   = 1'b0;
      rsp_in      = rsp_ff;
      cmd.op      = CELL_HOLD;
      cmd.data    = value_ff;
      dump_value  = backward_ff ? tail_value : head_value;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (req_data.op)
                  OP_INSERT_FRONT, OP_INSERT_BACK: begin
                     strobe_in      = 1'b1;
                     rsp_in.element = req_data.value;
                     rsp_in.last    = 1'b1;
                     if (count_ff == Full) begin
                        rsp_in.status = STAT_FULL;
                     end else begin
                        rsp_in.status = STAT_INSERTED;
                        cmd.op   = (req_data.op == OP_INSERT_FRONT) ? CELL_SHIFT_IN : CELL_LOAD;
                        cmd.data = req_data.value;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_DELETE: begin
                     value_in = req_data.value;
                     state_in = ST_DELETE;
                  end
                  OP_DUMP_FWD, OP_DUMP_BWD: begin
                     if (count_ff == '0) begin
                        strobe_in      = 1'b1;
                        rsp_in.status  = STAT_EMPTY;
                        rsp_in.element = '0;
                        rsp_in.last    = 1'b1;
                     end else begin
                        backward_in = (req_data.op == OP_DUMP_BWD);
                        remain_in   = count_ff;
                        state_in    = ST_DUMP;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_DELETE: begin
            cmd.op         = CELL_DELETE;
            cmd.data       = value_ff;
            strobe_in      = 1'b1;
            rsp_in.element = value_ff;
            rsp_in.last    = 1'b1;
            if (found) begin
               rsp_in.status = STAT_DELETED;
               count_in      = count_ff - 1'b1;
            end else begin
               rsp_in.status = STAT_NOT_FOUND;
            end
            state_in = ST_IDLE;
         end
         ST_DUMP: begin
            // rotate the occupied slots so the next entry comes to the end
            cmd.op         = backward_ff ? CELL_ROT_RIGHT : CELL_ROT_LEFT;
            cmd.data       = dump_value;
            strobe_in      = 1'b1;
            rsp_in.status  = STAT_ELEMENT;
            rsp_in.element = dump_value;
            rsp_in.last    = (remain_ff == CntW'(1));
            remain_in      = remain_ff - 1'b1;
            if (remain_ff == CntW'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
      remain_ff   <= remain_in;
      backward_ff <= backward_in;
      value_ff    <= value_in;
      rsp_ff      <= rsp_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;
   assign count      = count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= Full)
      else $error("entry count above depth");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && count_ff != Full &&
       (req_data.op == OP_INSERT_FRONT || req_data.op == OP_INSERT_BACK))
      |=> (count_ff == $past(count_ff) + 1'b1) && rsp_strobe)
      else $error("insert did not grow list or report");

   a_dump_streams: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DUMP) |=> rsp_strobe && rsp_data.status == STAT_ELEMENT)
      else $error("dump cycle without an element transfer");

   a_last_only_at_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.last) |-> (state_ff == ST_DUMP))
      else $error("non-final result outside a dump");

   a_delete_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DELETE) |=> (state_ff == ST_IDLE) && rsp_strobe)
      else $error("delete did not finish in one pass");

endmodule
`default_nettype wire

// ===== design/ordered_deque_with_delete.sv =====
// Top level: ordered deque of signed 32-bit values built as a row of slot cells.
// Commands transfer when start is high and busy is low. An insert leaves busy
// low and a new command can follow at once; a delete keeps busy high for its
// delete state, in which every cell compares against the value and the slots
// behind the first match move up one place; a dump keeps busy high until every
// entry has been sent, since the occupied cells rotate by one slot per cycle to
// bring each entry to the head or the tail. Every result appears on rsp_data,
// marked by rsp_strobe high for a single cycle, in the cycle after the work that
// forms it; the receiver cannot stall and must take each one as it comes. Entry
// storage is not reset; only the entry count, state and result strobe are.
`default_nettype none
module ordered_deque_with_delete
   import odd_pkg::*;
#(
   parameter int unsigned DEPTH = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire req_type req_data,
   output logic         busy,
   output logic         rsp_strobe,
   output rsp_type      rsp_data
);

   localparam int unsigned CntW = $clog2(DEPTH + 1);

   cell_cmd_type       cmd;
   logic [CntW-1:0]    count;
   logic signed [31:0] cell_value [DEPTH];
   logic               found_chain [DEPTH+1];
   logic signed [31:0] tail_value;

   assign found_chain[0] = 1'b0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [31:0] left_value;
      logic signed [31:0] right_value;
      if (i == 0) begin : g_first
         assign left_value = cmd.data;
      end else begin : g_mid
         assign left_value = cell_value[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_value = cell_value[i];
      end else begin : g_inner
         assign right_value = cell_value[i+1];
      end
      odd_cell #(
         .DEPTH (DEPTH),
         .INDEX (i)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .count       (count),
         .left_value  (left_value),
         .right_value (right_value),
         .found_in    (found_chain[i]),
         .value       (cell_value[i]),
         .found_out   (found_chain[i+1])
      );
   end

   // tail is the slot at count - 1
   always_comb begin
      tail_value = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (CntW'(i + 1) == count) begin
            tail_value = tail_value | cell_value[i];
         end
      end
   end

   odd_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_data   (req_data),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .count      (count),
      .cmd        (cmd),
      .head_value (cell_value[0]),
      .tail_value (tail_value),
      .found      (found_chain[DEPTH])
   );

endmodule
`default_nettype wire
